@@ hdl/cross_correlation_lag_direction_macros.svh @@
// Assertion macros for the cross-correlation lag direction block.
// No dependencies; included by the files that check their own logic.
`ifndef CROSS_CORRELATION_LAG_DIRECTION_MACROS_SVH
`define CROSS_CORRELATION_LAG_DIRECTION_MACROS_SVH
`ifndef SYNTH
`define CCLD_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("ccld check failed");
`define CCLD_IMPLY(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("ccld check failed");
`else
`define CCLD_ASSERT(lbl, clk_s, rst_s, prop)
`define CCLD_IMPLY(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

@@ hdl/ccld_pkg.sv @@
// Shared constants, types and elaboration-time angle table functions.
// No dependencies.
`default_nettype none
package ccld_pkg;

    localparam int WINDOW_DEF      = 1024;
    localparam int MAX_LAG_DEF     = 100;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SAMPLE_RATE_DEF = 44100;

    localparam int ACC_W              = 48;
    localparam int HALF_PI_Q13        = 12868;
    localparam int SPEED_OVER_SPACING = 3430;
    localparam int LAG_OUT_W          = 8;
    localparam int ANGLE_W            = 15;

    typedef struct packed {
        logic full;
        logic empty;
        logic any_window;
    } queue_status_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    function automatic logic [63:0] term_div(input int k);
        logic [63:0] d;
        unique case (k)
            1:       d = 64'd6;
            2:       d = 64'd20;
            3:       d = 64'd42;
            4:       d = 64'd72;
            5:       d = 64'd110;
            6:       d = 64'd156;
            default: d = 64'd210;
        endcase
        return d;
    endfunction

    // Truncating unsigned quotient by restoring shift and subtract
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q30 sine by Taylor series up to the x^15 term
    function automatic logic signed [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 7; k++) begin
            term = div_u64((term * x2) >> 30, term_div(k));
            if ((k % 2) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return sum;
    endfunction

    // {clipped, magnitude} for |lag| = mag
    function automatic logic [15:0] angle_entry(input int mag, input int rate);
        logic [63:0] n;
        logic [63:0] lim;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic signed [63:0] s;
        logic [15:0] r;
        n   = 64'(mag) * 64'(SPEED_OVER_SPACING);
        lim = n << 30;
        lo  = 64'd0;
        hi  = 64'(HALF_PI_Q13);
        if (n > 64'(rate)) begin
            r = {1'b1, 15'(HALF_PI_Q13)};
        end
        else if (n == 64'(rate)) begin
            r = {1'b0, 15'(HALF_PI_Q13)};
        end
        else begin
            for (int it = 0; it < 16; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    s   = sin_q30((64'd2 * mid - 64'd1) << 16);
                    if ((s <= 0) || ($unsigned(s) * 64'(rate) <= lim))
                        lo = mid;
                    else
                        hi = mid - 64'd1;
                end
            end
            r = {1'b0, lo[14:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/ccld_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ccld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ hdl/ccld_queue.sv @@
// Two-entry job queue between the front and back parts.
// Depends on ccld_pkg.
`default_nettype none
module ccld_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire logic                    push_window,
    input  wire logic                    pop,
    output logic                         head_window,
    output ccld_pkg::queue_status_t      stat
);
    import ccld_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] win_reg, win_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        win_next = win_reg;
        if (pop)
        begin
            win_next = {1'b0, win_reg[1]};
            cnt_next = cnt_reg - 2'd1;
        end
        if (push)
        begin
            win_next[cnt_next[0]] = push_window;
            cnt_next = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            win_reg <= 2'b00;
        end
        else
        begin
            cnt_reg <= cnt_next;
            win_reg <= win_next;
        end
    end

    assign head_window     = win_reg[0];
    assign stat.full       = cnt_reg[1];
    assign stat.empty      = (cnt_reg == 2'd0);
    assign stat.any_window = (win_reg[0] && cnt_reg != 2'd0) || (win_reg[1] && cnt_reg[1]);
endmodule
`default_nettype wire

@@ hdl/ccld_front.sv @@
// Input side: store sample pairs and queue a job on each last beat.
// Depends on ccld_pkg.
`default_nettype none
module ccld_front #(
    parameter int WINDOW      = ccld_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = ccld_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_a,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_b,
    input  wire logic                          last,
    output logic                               wr_en,
    output logic [$clog2(WINDOW)-1:0]          wr_addr,
    output logic [SAMPLE_BITS-1:0]             wr_a,
    output logic [SAMPLE_BITS-1:0]             wr_b,
    output logic                               push,
    output logic                               push_window,
    input  wire ccld_pkg::queue_status_t       q_stat,
    input  wire ccld_pkg::back_status_t        b_stat
);
    import ccld_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);
    localparam int AW = $clog2(WINDOW);

    logic [CW-1:0] count_reg, count_next;
    logic          fire;
    logic          room;

    // Hold input while a window job is queued or running: it reads the stores.
    assign item_ready  = !q_stat.full && !q_stat.any_window && !b_stat.busy;
    assign fire        = item_valid && item_ready;
    assign room        = (count_reg < CW'(WINDOW));
    assign wr_en       = fire && room;
    assign wr_addr     = count_reg[AW-1:0];
    assign wr_a        = sample_a;
    assign wr_b        = sample_b;
    assign push        = fire && last;
    assign push_window = (count_reg == CW'(WINDOW)) || (count_reg == CW'(WINDOW - 1));

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            if (last)
                count_next = '0;
            else if (room)
                count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end
endmodule
`default_nettype wire

@@ hdl/ccld_back.sv @@
// Correlation sequencer: one MAC over all lags, best-lag search, angle ROM.
// Depends on ccld_pkg; reads the two sample RAMs.
`default_nettype none
module ccld_back #(
    parameter int WINDOW      = ccld_pkg::WINDOW_DEF,
    parameter int MAX_LAG     = ccld_pkg::MAX_LAG_DEF,
    parameter int SAMPLE_BITS = ccld_pkg::SAMPLE_BITS_DEF,
    parameter int SAMPLE_RATE = ccld_pkg::SAMPLE_RATE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ccld_pkg::queue_status_t       q_stat,
    input  wire logic                          head_window,
    output logic                               pop,
    output ccld_pkg::back_status_t             b_stat,
    output logic [$clog2(WINDOW)-1:0]          rd_addr_a,
    output logic [$clog2(WINDOW)-1:0]          rd_addr_b,
    input  wire logic [SAMPLE_BITS-1:0]        rd_a,
    input  wire logic [SAMPLE_BITS-1:0]        rd_b,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic signed [ccld_pkg::LAG_OUT_W-1:0] best_lag,
    output logic signed [ccld_pkg::ANGLE_W-1:0]   angle,
    output logic                               window_full,
    output logic                               angle_clipped
);
    import ccld_pkg::*;

    localparam int AW     = $clog2(WINDOW);
    localparam int LAG_W  = $clog2(MAX_LAG + 1) + 1;
    localparam int PW     = 2 * SAMPLE_BITS;
    localparam bit EMPTY  = (WINDOW - 2 * MAX_LAG) <= 0;
    localparam int I_LAST = EMPTY ? 0 : WINDOW - MAX_LAG - 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic signed [LAG_W-1:0] lag_reg, lag_next;
    logic signed [LAG_W-1:0] win_reg, win_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic signed [ACC_W-1:0] sum_reg, sum_next;
    logic signed [ACC_W-1:0] best_reg, best_next;
    logic                    v1_reg, pv_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    can_out;
    logic                    load_zero, load_res;
    logic signed [AW+1:0]    b_sum;
    logic [LAG_W-1:0]        mag;
    logic [15:0]             rom [MAX_LAG+1];
    logic [15:0]             entry;

    for (genvar g = 0; g <= MAX_LAG; g++)
    begin : g_rom
        localparam logic [15:0] E = angle_entry(g, SAMPLE_RATE);
        assign rom[g] = E;
    end

    assign can_out   = !result_valid || result_ready;
    assign b_sum     = $signed({2'b00, idx_reg}) + (AW+2)'(lag_reg);
    assign rd_addr_a = idx_reg;
    assign rd_addr_b = b_sum[AW-1:0];
    assign mag       = win_reg[LAG_W-1] ? LAG_W'(-win_reg) : LAG_W'(win_reg);
    assign entry     = rom[mag[LAG_W-2:0]];
    assign b_stat.busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        lag_next   = lag_reg;
        win_next   = win_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        pop        = 1'b0;
        load_zero  = 1'b0;
        load_res   = 1'b0;
        if (pv_reg)
            sum_next = sum_reg + ACC_W'(prod_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty && can_out)
                begin
                    pop = 1'b1;
                    if (head_window)
                    begin
                        lag_next   = -LAG_W'(MAX_LAG);
                        win_next   = '0;
                        idx_next   = AW'(MAX_LAG);
                        sum_next   = '0;
                        best_next  = -(ACC_W'(1) << 30);
                        state_next = EMPTY ? ST_DRAIN : ST_RUN;
                    end
                    else
                        load_zero = 1'b1;
                end
            end
            ST_RUN:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(I_LAST))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !pv_reg)
                begin
                    if (sum_reg > best_reg)
                    begin
                        best_next = sum_reg;
                        win_next  = lag_reg;
                    end
                    if (lag_reg == LAG_W'(MAX_LAG))
                        state_next = ST_FIN;
                    else
                    begin
                        lag_next   = lag_reg + LAG_W'(1);
                        idx_next   = AW'(MAX_LAG);
                        sum_next   = '0;
                        state_next = EMPTY ? ST_DRAIN : ST_RUN;
                    end
                end
            end
            ST_FIN:
            begin
                if (can_out)
                begin
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            v1_reg       <= 1'b0;
            pv_reg       <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_RUN);
            pv_reg    <= v1_reg;
            if (load_zero || load_res)
                result_valid <= 1'b1;
            else if (result_ready)
                result_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        lag_reg  <= lag_next;
        win_reg  <= win_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        best_reg <= best_next;
        prod_reg <= $signed(rd_a) * $signed(rd_b);
        if (load_zero)
        begin
            best_lag      <= '0;
            angle         <= '0;
            window_full   <= 1'b0;
            angle_clipped <= 1'b0;
        end
        else if (load_res)
        begin
            best_lag      <= LAG_OUT_W'(win_reg);
            angle         <= win_reg[LAG_W-1] ? -$signed(entry[14:0]) : $signed(entry[14:0]);
            window_full   <= 1'b1;
            angle_clipped <= entry[15];
        end
    end
endmodule
`default_nettype wire

@@ hdl/cross_correlation_lag_direction.sv @@
// Top level of the two-microphone cross-correlation direction finder.
// Depends on ccld_pkg, ccld_ram, ccld_queue, ccld_front, ccld_back and the macros header.
//
// Feed sample pairs as beats; the first WINDOW pairs of a window are kept and
// the rest are dropped until a beat with last set. That beat yields one result:
// the lag in -MAX_LAG..MAX_LAG with the largest 48-bit correlation sum (first
// one wins ties), and the arrival angle in Q2.13 radians from a ROM built at
// elaboration, saturated to +-pi/2 with angle_clipped set when the sine
// argument exceeds one. A window closed early gives all-zero outputs with
// window_full low. Ordinary beats are accepted back to back while item_ready
// is high. A full window runs a single multiply-accumulate unit fed by the two
// sample RAMs: each of the 2*MAX_LAG+1 lags sums WINDOW-2*MAX_LAG products
// through the RAM read, product and accumulator registers, then drains the
// pipeline and compares the sum with the best so far. Input is held off
// while that job runs, since it reads the stores; a short-window job does not.
// The result sits in an output register so the next window can be taken in
// while it waits.
`default_nettype none
`include "cross_correlation_lag_direction_macros.svh"
module cross_correlation_lag_direction #(
    parameter int WINDOW      = ccld_pkg::WINDOW_DEF,
    parameter int MAX_LAG     = ccld_pkg::MAX_LAG_DEF,
    parameter int SAMPLE_BITS = ccld_pkg::SAMPLE_BITS_DEF,
    parameter int SAMPLE_RATE = ccld_pkg::SAMPLE_RATE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_a,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_b,
    input  wire logic                          last,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic signed [ccld_pkg::LAG_OUT_W-1:0] best_lag,
    output logic signed [ccld_pkg::ANGLE_W-1:0]   angle,
    output logic                               window_full,
    output logic                               angle_clipped
);
    import ccld_pkg::*;

    localparam int AW = $clog2(WINDOW);

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_BITS-1:0] wr_a, wr_b;
    logic [AW-1:0]          rd_addr_a, rd_addr_b;
    logic [SAMPLE_BITS-1:0] rd_a, rd_b;
    logic                   push, push_window, pop, head_window;
    queue_status_t          q_stat;
    back_status_t           b_stat;

    // Front: write sample pairs, queue one job per last beat.
    ccld_front #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk, .rst_n, .item_valid, .item_ready, .sample_a, .sample_b, .last,
        .wr_en, .wr_addr, .wr_a, .wr_b, .push, .push_window, .q_stat, .b_stat
    );

    ccld_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_store_a (
        .clk, .wr_en, .wr_addr, .wr_data(wr_a), .rd_addr(rd_addr_a), .rd_data(rd_a)
    );

    ccld_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_store_b (
        .clk, .wr_en, .wr_addr, .wr_data(wr_b), .rd_addr(rd_addr_b), .rd_data(rd_b)
    );

    // Job queue decouples the input side from the correlation engine.
    ccld_queue u_queue (
        .clk, .rst_n, .push, .push_window, .pop, .head_window, .stat(q_stat)
    );

    // Back: correlate, pick the best lag, look up the angle.
    ccld_back #(
        .WINDOW(WINDOW), .MAX_LAG(MAX_LAG),
        .SAMPLE_BITS(SAMPLE_BITS), .SAMPLE_RATE(SAMPLE_RATE)
    ) u_back (
        .clk, .rst_n, .q_stat, .head_window, .pop, .b_stat,
        .rd_addr_a, .rd_addr_b, .rd_a, .rd_b,
        .result_valid, .result_ready, .best_lag, .angle, .window_full, .angle_clipped
    );

    // Stores are never written while a window job reads them.
    `CCLD_IMPLY(a_no_write_busy, clk, rst_n, wr_en, !b_stat.busy && !q_stat.any_window)
    // Never push into a full queue.
    `CCLD_IMPLY(a_no_overflow, clk, rst_n, push, !q_stat.full)
    // A short-window result is all zero.
    `CCLD_IMPLY(a_short_zero, clk, rst_n, result_valid && !window_full,
        best_lag == '0 && angle == '0 && !angle_clipped)
endmodule
`default_nettype wire

@@ verif/cross_correlation_lag_direction_tb.sv @@
// Testbench for the two-microphone cross-correlation direction finder.
// Depends on ccld_pkg and the cross_correlation_lag_direction top level.
`default_nettype none
module cross_correlation_lag_direction_tb;
    import ccld_pkg::*;

    localparam int NWIN   = WINDOW_DEF;
    localparam int MLAG   = MAX_LAG_DEF;
    localparam int RATE   = SAMPLE_RATE_DEF;
    localparam int LIMIT  = 3000000;
    localparam int SETTLE = 200;

    typedef struct {
        logic signed [LAG_OUT_W-1:0] lag;
        logic signed [ANGLE_W-1:0]   ang;
        logic                        full;
        logic                        clip;
    } direction_t;

    // Own model of the block: sample stores, fill count and the lag search.
    class direction_scoreboard;
        logic signed [15:0] store_a [NWIN];
        logic signed [15:0] store_b [NWIN];
        int                 fill;
        direction_t         pending [$];
        int                 errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        // Q30 sine, Taylor series to the x^15 term with truncating steps
        function logic signed [63:0] sine_q30(input logic [63:0] x);
            logic [63:0] x2;
            logic [63:0] term;
            logic signed [63:0] acc;
            x2   = (x * x) >> 30;
            term = x;
            acc  = $signed(x);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
                if (k % 2 == 1)
                    acc = acc - $signed(term);
                else
                    acc = acc + $signed(term);
            end
            return acc;
        endfunction

        function direction_t solve_direction();
            direction_t         r;
            logic signed [47:0] acc;
            logic signed [47:0] best;
            int                 win;
            int                 mag;
            logic [63:0]        n;
            int                 lo;
            int                 hi;
            int                 mid;
            logic signed [63:0] s;
            best = -48'sd1073741824;
            win  = 0;
            for (int lag = -MLAG; lag <= MLAG; lag++) begin
                acc = '0;
                for (int i = MLAG; i < NWIN - MLAG; i++) begin
                    if (i + lag >= 0 && i + lag < NWIN)
                        acc = acc + 48'(longint'(store_a[i]) * longint'(store_b[i + lag]));
                end
                if (acc > best) begin
                    best = acc;
                    win  = lag;
                end
            end
            mag    = (win < 0) ? -win : win;
            n      = 64'(mag) * 64'(SPEED_OVER_SPACING);
            r.full = 1'b1;
            r.clip = 1'b0;
            r.lag  = LAG_OUT_W'(win);
            if (n > 64'(RATE)) begin
                r.clip = 1'b1;
                lo = HALF_PI_Q13;
            end
            else if (n == 64'(RATE)) begin
                lo = HALF_PI_Q13;
            end
            else begin
                lo = 0;
                hi = HALF_PI_Q13;
                while (lo < hi) begin
                    mid = (lo + hi + 1) / 2;
                    s   = sine_q30(64'(2 * mid - 1) << 16);
                    if (s <= 0 || $unsigned(s) * 64'(RATE) <= (n << 30))
                        lo = mid;
                    else
                        hi = mid - 1;
                end
            end
            r.ang = ANGLE_W'((win < 0) ? -lo : lo);
            return r;
        endfunction

        // Note one accepted input beat; queue a result when it closes a window.
        function void note_beat(input logic signed [15:0] a, input logic signed [15:0] b,
                                input logic fin);
            direction_t r;
            if (fill < NWIN) begin
                store_a[fill] = a;
                store_b[fill] = b;
                fill++;
            end
            if (fin) begin
                if (fill < NWIN) begin
                    r.lag  = '0;
                    r.ang  = '0;
                    r.full = 1'b0;
                    r.clip = 1'b0;
                end
                else begin
                    r = solve_direction();
                end
                fill = 0;
                pending.insert(pending.size(), r);
            end
        endfunction

        task check_result(input direction_t got);
            direction_t want;
            if (pending.size() == 0) begin
                report("result with nothing expected");
            end
            else begin
                want = pending.pop_front();
                if (got.lag !== want.lag)
                    report($sformatf("best_lag %0d want %0d", got.lag, want.lag));
                if (got.ang !== want.ang)
                    report($sformatf("angle %0d want %0d", got.ang, want.ang));
                if (got.full !== want.full)
                    report($sformatf("window_full %0b want %0b", got.full, want.full));
                if (got.clip !== want.clip)
                    report($sformatf("angle_clipped %0b want %0b", got.clip, want.clip));
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic signed [15:0]   sample_a = '0;
    logic signed [15:0]   sample_b = '0;
    logic                 last = 1'b0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic signed [LAG_OUT_W-1:0] best_lag;
    logic signed [ANGLE_W-1:0]   angle;
    logic                 window_full;
    logic                 angle_clipped;

    // Idling on both sides; cleared for the final stretch of the run.
    bit                   gaps_on = 1'b1;
    int                   stall_left = 0;
    int                   cycles = 0;
    direction_scoreboard  sb = new();
    direction_t           seen;

    // Scratch buffer for shaped full windows
    logic signed [15:0]   pat_a [NWIN];

    cross_correlation_lag_direction DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .last          (last),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .best_lag      (best_lag),
        .angle         (angle),
        .window_full   (window_full),
        .angle_clipped (angle_clipped)
    );

    always #10 clk = ~clk;

    // Abort on a hung handshake or a runaway full-window job.
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: drop ready at random, in bursts of random length.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= 1'b1;
        end
    end

    // Check every result beat against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready) begin
            seen.lag  = best_lag;
            seen.ang  = angle;
            seen.full = window_full;
            seen.clip = angle_clipped;
            sb.check_result(seen);
        end
    end

    // Present one sample beat and hold it until accepted; idle first at random.
    task send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                   input logic fin);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item_valid <= 1'b1;
        sample_a   <= a;
        sample_b   <= b;
        last       <= fin;
        do @(posedge clk); while (!item_ready);
        sb.note_beat(a, b, fin);
    endtask

    task send_short(input int len);
        for (int i = 0; i < len; i++)
            send_pair(16'($urandom), 16'($urandom), i == len - 1);
    endtask

    // Full window with B a copy of A delayed by shift plus random extra beats,
    // so the correlation peak lands on a chosen lag.
    task send_full(input int shift, input int extra);
        int src;
        for (int i = 0; i < NWIN; i++)
            pat_a[i] = 16'($urandom);
        for (int i = 0; i < NWIN + extra; i++) begin
            src = i - shift;
            send_pair(i < NWIN ? pat_a[i] : 16'($urandom),
                      (src >= 0 && src < NWIN) ? pat_a[src] : 16'($urandom),
                      i == NWIN + extra - 1);
        end
    endtask

    task drain_results();
        item_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-beat windows at the sample extremes, then short ones.
        send_pair(16'sh7FFF, -16'sh8000, 1'b1);
        send_pair(-16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(-16'sh0001, -16'sh0001, 1'b1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_pair(-16'sh8000, -16'sh8000, 1'b0);
        send_pair(16'sh5555, -16'sh5556, 1'b1);
        send_short(5);
        send_short(9);

        // Hold the sender until every result is out.
        drain_results();

        // Random short windows, noisy content
        for (int w = 0; w < 35; w++)
            send_short($urandom_range(1, 40));

        // Last part: no idling. One full window with extra beats, then short windows;
        // lags past about 12 saturate the angle, smaller ones do not.
        drain_results();
        gaps_on = 1'b0;
        send_full($urandom_range(0, 40) - 20, $urandom_range(1, 30));
        for (int w = 0; w < 6; w++)
            send_short($urandom_range(1, 20));

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/ccld_pkg.sv
hdl/ccld_ram.sv
hdl/ccld_queue.sv
hdl/ccld_front.sv
hdl/ccld_back.sv
hdl/cross_correlation_lag_direction.sv
verif/cross_correlation_lag_direction_tb.sv
